[hw/rtl/fovf_pkg.sv]
// shared types and constants for the point field-of-view and range filter
`default_nettype none

package fovf_pkg;

  // field widths
  localparam int COORD_W    = 24;
  localparam int COT_W      = 32;
  localparam int SIN_W      = 17;
  localparam int SIN_FRAC   = 16;
  localparam int RANGE_W    = 23;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // derived arithmetic widths
  localparam int SQ_W       = 2 * COORD_W - 1;
  localparam int D2_W       = 2 * COORD_W;
  localparam int P_W        = COORD_W + COT_W;
  localparam int AZ_W       = P_W + 1;
  localparam int S2_W       = 2 * SIN_W;
  localparam int MR2_W      = 2 * RANGE_W;
  localparam int PL_W       = COORD_W + S2_W;
  localparam int PH_W       = D2_W - COORD_W + S2_W;
  localparam int PROD_W     = D2_W + S2_W;
  localparam int ELEV_SHIFT = 2 * SIN_FRAC;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WIDE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SIN   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RANGE = CFG_IDX_W'(3);

  // reset values
  localparam logic [SIN_W-1:0] SIN_RESET = SIN_W'(65536);

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      keep;
  } out_beat_t;

  typedef struct packed {
    logic signed [COT_W-1:0] cot_half_hfov;
    logic                    wide_mode;
    logic [SIN_W-1:0]        sin_half_vfov;
    logic [RANGE_W-1:0]      max_range;
  } fovf_cfg_t;

  // bundle handed from the front stages to the back stages
  typedef struct packed {
    in_beat_t           pt;
    logic [D2_W-1:0]    d2;
    logic [SQ_W-1:0]    z2;
    logic [S2_W-1:0]    s2;
    logic [MR2_W-1:0]   mr2;
    logic               azim_ok;
  } fovf_mid_t;

endpackage

`default_nettype wire

[hw/rtl/fovf_cfg_regs.sv]
// configuration register file of the filter
`default_nettype none

module fovf_cfg_regs
  import fovf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output fovf_cfg_t                  cfg
);

  logic      cfg_ready_r;
  fovf_cfg_t cfg_r;

  // ready comes up after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ready_r <= 1'b0;
    end else begin
      cfg_ready_r <= 1'b1;
    end
  end

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cot_half_hfov <= '0;
      cfg_r.wide_mode     <= 1'b0;
      cfg_r.sin_half_vfov <= SIN_RESET;
      cfg_r.max_range     <= '0;
    end else if (cfg_valid && cfg_ready_r) begin
      unique case (cfg_index)
        REG_COT:   cfg_r.cot_half_hfov <= $signed(cfg_data[COT_W-1:0]);
        REG_WIDE:  cfg_r.wide_mode     <= cfg_data[0];
        REG_SIN:   cfg_r.sin_half_vfov <= cfg_data[SIN_W-1:0];
        REG_RANGE: cfg_r.max_range     <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = cfg_ready_r;
  assign cfg       = cfg_r;

  // a sine write lands in the register
  a_sin_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == REG_SIN)
    |=> cfg.sin_half_vfov == $past(cfg_data[SIN_W-1:0]))
    else $error("sine register write lost");

endmodule

`default_nettype wire

[hw/rtl/fovf_front.sv]
// front stages: squares, cotangent product, distance sum and azimuth test
`default_nettype none

module fovf_front
  import fovf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire in_beat_t  in_beat,
  input  wire fovf_cfg_t cfg,
  output logic           mid_valid,
  output fovf_mid_t      mid
);

  // stage 1 registers
  logic                   v1_r;
  in_beat_t               pt1_r;
  logic [SQ_W-1:0]        x2_r, y2_r, z2_r;
  logic signed [P_W-1:0]  p1_r;
  logic [S2_W-1:0]        s2_r;
  logic [MR2_W-1:0]       mr2_r;

  // stage 2 registers
  logic                   v2_r;
  fovf_mid_t              mid_r;
  fovf_mid_t              mid_nxt;

  logic signed [D2_W-1:0] sqx, sqy, sqz;
  logic signed [P_W-1:0]  p_nxt;
  logic signed [AZ_W-1:0] yq, pe, pn;
  logic                   t1, t2;

  // stage 1 products, signed squares are never negative
  assign sqx   = D2_W'(in_beat.pos_x) * D2_W'(in_beat.pos_x);
  assign sqy   = D2_W'(in_beat.pos_y) * D2_W'(in_beat.pos_y);
  assign sqz   = D2_W'(in_beat.pos_z) * D2_W'(in_beat.pos_z);
  assign p_nxt = P_W'(in_beat.pos_x) * P_W'(cfg.cot_half_hfov);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pt1_r <= in_beat;
    x2_r  <= sqx[SQ_W-1:0];
    y2_r  <= sqy[SQ_W-1:0];
    z2_r  <= sqz[SQ_W-1:0];
    p1_r  <= p_nxt;
    s2_r  <= S2_W'(cfg.sin_half_vfov) * S2_W'(cfg.sin_half_vfov);
    mr2_r <= MR2_W'(cfg.max_range) * MR2_W'(cfg.max_range);
  end

  // stage 2 azimuth: y*2^16 against +/- x*cot
  assign yq = AZ_W'(pt1_r.pos_y) <<< SIN_FRAC;
  assign pe = AZ_W'(p1_r);
  assign pn = -pe;
  assign t1 = (yq >= pe);
  assign t2 = (yq >= pn);

  always_comb begin
    mid_nxt.pt      = pt1_r;
    mid_nxt.d2      = D2_W'(x2_r) + D2_W'(y2_r) + D2_W'(z2_r);
    mid_nxt.z2      = z2_r;
    mid_nxt.s2      = s2_r;
    mid_nxt.mr2     = mr2_r;
    mid_nxt.azim_ok = cfg.wide_mode ? (t1 || t2) : (t1 && t2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    mid_r <= mid_nxt;
  end

  assign mid_valid = v2_r;
  assign mid       = mid_r;

endmodule

`default_nettype wire

[hw/rtl/fovf_back.sv]
// back stages: range test, split elevation product and final keep flag
`default_nettype none

module fovf_back
  import fovf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      mid_valid,
  input  wire fovf_mid_t mid,
  output logic           out_valid,
  output out_beat_t      out_beat
);

  localparam int RC_W = (D2_W > MR2_W) ? D2_W : MR2_W;

  // stage 3 registers
  logic              v3_r;
  in_beat_t          pt3_r;
  logic [SQ_W-1:0]   z2_3_r;
  logic [PL_W-1:0]   pl_r;
  logic [PH_W-1:0]   ph_r;
  logic              ok3_r;

  // stage 4 registers
  logic              v4_r;
  in_beat_t          pt4_r;
  logic [SQ_W-1:0]   z2_4_r;
  logic [PROD_W-1:0] prod_r;
  logic              ok4_r;

  // output register
  logic              out_valid_r;
  out_beat_t         out_r;
  out_beat_t         out_nxt;

  logic              rng_ok;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] lhs;
  logic              elev_ok;

  // stage 3 range test and the two halves of d2 * sin^2
  assign rng_ok = (mid.mr2 == '0) || (RC_W'(mid.d2) <= RC_W'(mid.mr2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    pt3_r  <= mid.pt;
    z2_3_r <= mid.z2;
    pl_r   <= PL_W'(mid.d2[COORD_W-1:0]) * PL_W'(mid.s2);
    ph_r   <= PH_W'(mid.d2[D2_W-1:COORD_W]) * PH_W'(mid.s2);
    ok3_r  <= rng_ok && mid.azim_ok;
  end

  // stage 4 recombine the partial products
  assign prod_nxt = (PROD_W'(ph_r) << COORD_W) + PROD_W'(pl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    pt4_r  <= pt3_r;
    z2_4_r <= z2_3_r;
    prod_r <= prod_nxt;
    ok4_r  <= ok3_r;
  end

  // stage 5 elevation: z^2 * 2^32 <= d2 * sin^2
  assign lhs     = PROD_W'(z2_4_r) << ELEV_SHIFT;
  assign elev_ok = (lhs <= prod_r);

  always_comb begin
    out_nxt.out_x = pt4_r.pos_x;
    out_nxt.out_y = pt4_r.pos_y;
    out_nxt.out_z = pt4_r.pos_z;
    out_nxt.keep  = ok4_r && elev_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

endmodule

`default_nettype wire

[hw/rtl/point_fov_range_filter.sv]
// top level of the point field-of-view and range filter
// a point taken in is strobed on out_valid after the stage 1 to 4 and output registers
// throughput: one point per clock while busy is low
// reset: pipeline valids clear, configuration registers take their reset values, busy
// stays high through reset and clears on the clock after; results are never stalled
`default_nettype none

module point_fov_range_filter
  import fovf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_beat_t              in_data,
  output logic                       out_valid,
  output out_beat_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic      busy_r;
  logic      in_valid;
  fovf_cfg_t cfg;
  logic      mid_valid;
  fovf_mid_t mid;

  // busy only around reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy     = busy_r;
  assign in_valid = start && !busy_r;

  // configuration registers
  fovf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // squares and azimuth
  fovf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_beat   (in_data),
    .cfg       (cfg),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  // range, elevation and result beat
  fovf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (mid_valid),
    .mid       (mid),
    .out_valid (out_valid),
    .out_beat  (out_data)
  );

  // every accepted beat comes out on out_valid after the stage 1 to 4 and output registers
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("accepted point did not come out");

  // no result without an accepted beat earlier in the pipeline
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result strobe without an accepted point");

  // reset empties the pipeline and blocks input
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (busy && !out_valid))
    else $error("pipeline not cleared by reset");

endmodule

`default_nettype wire

[dv/tb_point_fov_range_filter.sv]
// self-checking testbench for the point field-of-view and range filter
`timescale 1ns / 1ps

module tb_point_fov_range_filter;
  import fovf_pkg::*;

  localparam int C_MAX = 8388607;
  localparam int C_MIN = -8388608;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(8'hA5);
  localparam int RAND_PHASES = 13;
  localparam int PHASE_POINTS = 150;
  localparam int MAX_SHOWN = 30;

  // one row of the directed plan: a register write or a point
  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    in_beat_t              pt;
    bit                    typed;
    bit                    keep;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  out_beat_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fovf_cfg_t   shadow_cfg;
  out_beat_t   pending_points[$];
  plan_row_t   plan[$];
  out_beat_t   want;
  int          errors = 0;
  int          points_sent = 0;
  int          kept_seen = 0;
  int          dropped_seen = 0;
  int          setups = 0;
  bit          idle_on;

  point_fov_range_filter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("timeout: %0d results still outstanding", pending_points.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // keep decision: range, azimuth and elevation tests on exact integers
  function automatic logic fov_keep(input in_beat_t p, input fovf_cfg_t c);
    longint x, y, z, dist2, zsq, mr, yq, prod, s, s2;
    logic [127:0] lhs, rhs;
    logic range_ok, t1, t2, azim_ok, elev_ok;
    x = longint'($signed(p.pos_x));
    y = longint'($signed(p.pos_y));
    z = longint'($signed(p.pos_z));
    zsq = z * z;
    dist2 = x * x + y * y + zsq;
    mr = longint'(c.max_range);
    range_ok = (mr == 0) || (dist2 <= mr * mr);
    yq = y * 65536;
    prod = x * longint'($signed(c.cot_half_hfov));
    t1 = yq >= prod;
    t2 = yq >= -prod;
    azim_ok = c.wide_mode ? (t1 || t2) : (t1 && t2);
    // z^2 * 2^32 against d^2 * sin^2, well clear of 128 bits
    s = longint'(c.sin_half_vfov);
    s2 = s * s;
    lhs = 128'(zsq);
    lhs = lhs << 32;
    rhs = 128'(dist2);
    rhs = rhs * 128'(s2);
    elev_ok = lhs <= rhs;
    return range_ok && azim_ok && elev_ok;
  endfunction

  // shadow copy of a register write; extra high bits drop, unknown index ignored
  function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_COT:   shadow_cfg.cot_half_hfov = data[COT_W-1:0];
      REG_WIDE:  shadow_cfg.wide_mode = data[0];
      REG_SIN:   shadow_cfg.sin_half_vfov = data[SIN_W-1:0];
      REG_RANGE: shadow_cfg.max_range = data[RANGE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic in_beat_t mk_point(input int x, input int y, input int z);
    in_beat_t p;
    p.pos_x = COORD_W'(x);
    p.pos_y = COORD_W'(y);
    p.pos_z = COORD_W'(z);
    return p;
  endfunction

  function automatic void add_point(input int x, input int y, input int z,
                                    input bit typed, input bit keep);
    plan_row_t r;
    r = '{default: '0};
    r.pt = mk_point(x, y, z);
    r.typed = typed;
    r.keep = keep;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.idx = idx;
    r.data = data;
    plan.insert(plan.size(), r);
  endfunction

  // one coordinate, drawn from a mix of full-scale, scaled, extreme and in-range values
  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned span);
    logic [COORD_W-1:0] v;
    int unsigned w;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      v = COORD_W'($urandom);
    end else if (r < 4) begin
      w = $urandom_range(1, COORD_W - 1);
      v = COORD_W'($urandom & ((1 << w) - 1));
      if ($urandom_range(0, 1)) v = -v;
    end else if (r == 4) begin
      case ($urandom_range(0, 4))
        0: v = COORD_W'(C_MIN);
        1: v = COORD_W'(C_MAX);
        2: v = '0;
        3: v = '1;
        default: v = COORD_W'(1);
      endcase
    end else begin
      v = COORD_W'(int'($urandom_range(0, 2 * span)) - int'(span));
    end
    return v;
  endfunction

  // present a point until the block takes it, then queue its expected result
  task automatic send_point(input in_beat_t pt, input bit typed, input bit keep);
    out_beat_t exp_beat;
    start <= 1'b1;
    in_data <= pt;
    do @(posedge clk); while (busy);
    exp_beat.out_x = pt.pos_x;
    exp_beat.out_y = pt.pos_y;
    exp_beat.out_z = pt.pos_z;
    exp_beat.keep = typed ? keep : fov_keep(pt, shadow_cfg);
    pending_points.insert(pending_points.size(), exp_beat);
    points_sent++;
  endtask

  // drop start and wait until every queued result has come back
  task automatic drain_points();
    start <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    shadow_write(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random register setup between phases, extremes weighted in
  task automatic load_random_setup();
    logic [CFG_DATA_W-1:0] d;
    drain_points();
    case ($urandom_range(0, 5))
      0: d = '0;
      1: d = CFG_DATA_W'(65536 * $urandom_range(1, 4));
      2: d = 32'h7FFF_FFFF;
      3: d = 32'h8000_0000;
      4: d = $urandom;
      default: d = CFG_DATA_W'($urandom_range(0, 1 << 20));
    endcase
    if (d != 32'h8000_0000 && $urandom_range(0, 1)) d = -d;
    write_reg(REG_COT, d);
    write_reg(REG_WIDE, $urandom);
    case ($urandom_range(0, 4))
      0: d = 32'd65536;
      1: d = '0;
      2: d = 32'd131071;
      default: d = CFG_DATA_W'($urandom_range(0, 65536));
    endcase
    if ($urandom_range(0, 3) == 0) d = d | ($urandom & 32'hFFFE_0000);
    write_reg(REG_SIN, d);
    case ($urandom_range(0, 4))
      0: d = '0;
      1: d = 32'h007F_FFFF;
      2: d = $urandom;
      default: d = CFG_DATA_W'($urandom_range(1, 8000));
    endcase
    write_reg(REG_RANGE, d);
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(4, 255)), $urandom);
    setups++;
  endtask

  // result checker: one beat per strobe against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_points.size() == 0) begin
        note_mismatch("result beat with nothing expected");
      end else begin
        want = pending_points.pop_front();
        if (out_data.out_x !== want.out_x)
          note_mismatch($sformatf("out_x %h, want %h", out_data.out_x, want.out_x));
        if (out_data.out_y !== want.out_y)
          note_mismatch($sformatf("out_y %h, want %h", out_data.out_y, want.out_y));
        if (out_data.out_z !== want.out_z)
          note_mismatch($sformatf("out_z %h, want %h", out_data.out_z, want.out_z));
        if (out_data.keep !== want.keep)
          note_mismatch($sformatf("keep %b, want %b for (%h,%h,%h)", out_data.keep,
                                  want.keep, want.out_x, want.out_y, want.out_z));
        if (out_data.keep === 1'b1) kept_seen++;
        else dropped_seen++;
      end
    end
  end

  // stimulus
  initial begin
    shadow_cfg.cot_half_hfov = '0;
    shadow_cfg.wide_mode = 1'b0;
    shadow_cfg.sin_half_vfov = SIN_RESET;
    shadow_cfg.max_range = '0;

    // reset setup: only the sign of y matters
    add_point(0, 0, 0, 1, 1'b1);
    add_point(C_MAX, C_MAX, C_MAX, 1, 1'b1);
    add_point(C_MIN, C_MIN, C_MIN, 1, 1'b0);
    add_point(C_MIN, C_MAX, C_MIN, 1, 1'b1);
    add_point(C_MAX, C_MIN, C_MAX, 1, 1'b0);
    add_point(0, -1, 0, 1, 1'b0);
    add_point(1, 0, -1, 1, 1'b1);
    add_point(-1, 0, C_MAX, 1, 1'b1);
    // range 100 with junk above the field, then a write to no register
    add_write(REG_RANGE, 32'hFF80_0064);
    add_write(REG_UNUSED, 32'h0000_0001);
    add_point(100, 0, 0, 1, 1'b1);
    add_point(101, 0, 0, 1, 1'b0);
    add_point(0, -100, 0, 1, 1'b0);
    add_point(58, 58, 57, 0, 1'b0);
    // zero sine: only points with z of zero survive
    add_write(REG_SIN, 32'h0);
    add_write(REG_RANGE, 32'h0);
    add_point(0, 5, 1, 1, 1'b0);
    add_point(0, 5, 0, 1, 1'b1);
    // sine above one, 90 degree wedge
    add_write(REG_SIN, 32'd131071);
    add_write(REG_COT, 32'd65536);
    add_point(5, 3, 0, 1, 1'b0);
    add_point(-3, 5, 0, 1, 1'b1);
    add_point(3, 5, 9, 0, 1'b0);
    // wide mode via an all-ones write, cotangent at both extremes
    add_write(REG_WIDE, 32'hFFFF_FFFF);
    add_write(REG_COT, 32'h8000_0000);
    add_point(1, 0, 0, 0, 1'b0);
    add_point(-1, -1, 0, 0, 1'b0);
    add_point(C_MAX, C_MIN, 0, 0, 1'b0);
    add_write(REG_COT, 32'h7FFF_FFFF);
    add_write(REG_RANGE, 32'h007F_FFFF);
    add_point(C_MIN, C_MAX, C_MIN, 0, 1'b0);
    add_point(1, -1, 1, 0, 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed plan
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain_points();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_point(plan[i].pt, plan[i].typed, plan[i].keep);
      end
    end

    // random phases, each under a fresh register setup; the last two run flat out
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      load_random_setup();
      idle_on = (ph < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_POINTS; n++) begin
        int unsigned span;
        in_beat_t pt;
        span = (shadow_cfg.max_range != 0) ? shadow_cfg.max_range
                                           : $urandom_range(1, 4096);
        pt.pos_x = pick_coord(span);
        pt.pos_y = pick_coord(span);
        pt.pos_z = pick_coord(span);
        send_point(pt, 1'b0, 1'b0);
        if (idle_on && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk);
        end
      end
    end

    drain_points();
    repeat (8) @(posedge clk);
    $display("sent %0d points under %0d random register setups plus directed cases",
             points_sent, setups);
    $display("results seen: %0d kept, %0d dropped, %0d mismatches",
             kept_seen, dropped_seen, errors);
    if (errors == 0 && pending_points.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
